FILE: hdl/stlm_pkg.sv
`default_nettype none
package stlm_pkg;

  localparam int LIST_DEPTH_DEF  = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int ITEM_W          = 32;

  // action codes
  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_MERGE  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_SUCCESS  = 2'd0;
  localparam logic [1:0] ST_UNSORTED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // datapath ops
  localparam logic [1:0] OP_NOP      = 2'd0;
  localparam logic [1:0] OP_ACCEPT   = 2'd1;
  localparam logic [1:0] OP_EMIT_ERR = 2'd2;
  localparam logic [1:0] OP_EMIT_MRG = 2'd3;

  // jump conditions
  localparam logic [1:0] JC_DISPATCH = 2'd0;
  localparam logic [1:0] JC_CHECK    = 2'd1;
  localparam logic [1:0] JC_DONE     = 2'd2;
  localparam logic [1:0] JC_ALWAYS   = 2'd3;

  // step addresses
  localparam int          STEP_W   = 3;
  localparam logic [2:0]  S_IDLE   = 3'd0;
  localparam logic [2:0]  S_CHECK  = 3'd1;
  localparam logic [2:0]  S_MERGE  = 3'd2;
  localparam logic [2:0]  S_OVF    = 3'd3;
  localparam logic [2:0]  S_EMPTY  = 3'd4;
  localparam logic [2:0]  S_UNSORT = 3'd5;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        status;
    logic              clr;
    logic [1:0]        jcond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic       in_fire;
    logic [1:0] action;
    logic       full_a;
    logic       full_b;
    logic       empty;
    logic       unsorted;
    logic       emit_done;
  } cond_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_NOP, status: ST_SUCCESS, clr: 1'b0, jcond: JC_ALWAYS, target: S_IDLE};
    case (step)
      S_IDLE: begin
        w = '{op: OP_ACCEPT, status: ST_SUCCESS, clr: 1'b0, jcond: JC_DISPATCH,
              target: S_IDLE};
      end
      S_CHECK: begin
        w = '{op: OP_NOP, status: ST_SUCCESS, clr: 1'b0, jcond: JC_CHECK,
              target: S_MERGE};
      end
      S_MERGE: begin
        w = '{op: OP_EMIT_MRG, status: ST_SUCCESS, clr: 1'b1, jcond: JC_DONE,
              target: S_IDLE};
      end
      S_OVF: begin
        w = '{op: OP_EMIT_ERR, status: ST_OVERFLOW, clr: 1'b0, jcond: JC_DONE,
              target: S_IDLE};
      end
      S_EMPTY: begin
        w = '{op: OP_EMIT_ERR, status: ST_EMPTY, clr: 1'b1, jcond: JC_DONE,
              target: S_IDLE};
      end
      S_UNSORT: begin
        w = '{op: OP_EMIT_ERR, status: ST_UNSORTED, clr: 1'b1, jcond: JC_DONE,
              target: S_IDLE};
      end
      default: begin
        w = '{op: OP_NOP, status: ST_SUCCESS, clr: 1'b0, jcond: JC_ALWAYS,
              target: S_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sorted_two_list_merge_top.sv
`default_nettype none
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+------------------------------
// input   | in        | in_valid/in_ready  | action, item_value
// output  | out       | out_valid/out_ready| merged_value, status, last
//
// A load is done in the accept step. A merge passes the accept and check
// steps, then emits one result per cycle while the output is not stalled
// (count_a + count_b results), paced by the single read port of each list
// memory and by the output register. An empty or unsorted error result
// follows the check step; an overflow result follows accept directly.
// Synchronous reset clears counts and sorted flags; list memories are not
// cleared. A stalled output holds the sequencer on its emit step.
module sorted_two_list_merge_top #(
  parameter int LIST_DEPTH  = stlm_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = stlm_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic [1:0]                          action,
  input  wire logic signed [stlm_pkg::ITEM_W-1:0]  item_value,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic signed [stlm_pkg::ITEM_W-1:0]  merged_value,
  output      logic [1:0]                          status,
  output      logic                                last
);

  // count width holds the depth itself; address width indexes the memory
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int SW = CW + 1;

  stlm_pkg::ctrl_t ctrl;
  stlm_pkg::cond_t cond;

  logic signed [VALUE_WIDTH-1:0] mem_a [LIST_DEPTH];
  logic signed [VALUE_WIDTH-1:0] mem_b [LIST_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_a;
  logic signed [VALUE_WIDTH-1:0] rd_b;
  logic signed [VALUE_WIDTH-1:0] last_a;
  logic signed [VALUE_WIDTH-1:0] last_b;

  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic          sorted_a;
  logic          sorted_b;
  logic [CW-1:0] ia;
  logic [CW-1:0] ib;
  logic [CW-1:0] ia_next;
  logic [CW-1:0] ib_next;

  logic signed [63:0]            in_wide;
  logic signed [VALUE_WIDTH-1:0] load_val;
  logic signed [VALUE_WIDTH-1:0] pick_val;
  logic signed [63:0]            pick_wide;

  logic in_fire;
  logic load_a;
  logic load_b;
  logic full_a;
  logic full_b;
  logic a_avail;
  logic b_avail;
  logic take_a;
  logic last_elem;
  logic slot_free;
  logic emit_fire;
  logic emit_last;
  logic clear_now;

  stlm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctrl (ctrl)
  );

  // ---------------- input side ----------------
  assign in_ready = (ctrl.op == stlm_pkg::OP_ACCEPT);
  assign in_fire  = in_valid && in_ready;

  // sign-extend (or narrow) the item into the value width
  assign in_wide  = 64'(item_value);
  assign load_val = in_wide[VALUE_WIDTH-1:0];

  assign full_a = (count_a == CW'(LIST_DEPTH));
  assign full_b = (count_b == CW'(LIST_DEPTH));
  assign load_a = in_fire && (action == stlm_pkg::ACT_LOAD_A) && !full_a;
  assign load_b = in_fire && (action == stlm_pkg::ACT_LOAD_B) && !full_b;

  // ---------------- merge selection ----------------
  assign a_avail   = (ia < count_a);
  assign b_avail   = (ib < count_b);
  // ties go to list B
  assign take_a    = a_avail && (!b_avail || (rd_a < rd_b));
  assign pick_val  = take_a ? rd_a : rd_b;
  assign pick_wide = 64'(pick_val);
  assign last_elem = (SW'(ia) + SW'(ib) + SW'(1)) == (SW'(count_a) + SW'(count_b));

  // output register takes a new result when empty or being drained
  assign slot_free = !out_valid || out_ready;
  assign emit_fire = slot_free &&
                     ((ctrl.op == stlm_pkg::OP_EMIT_ERR) ||
                      (ctrl.op == stlm_pkg::OP_EMIT_MRG));
  assign emit_last = (ctrl.op == stlm_pkg::OP_EMIT_ERR) || last_elem;
  assign clear_now = emit_fire && emit_last && ctrl.clr;

  assign cond = '{in_fire:   in_fire,
                  action:    action,
                  full_a:    full_a,
                  full_b:    full_b,
                  empty:     (count_a == '0) || (count_b == '0),
                  unsorted:  !sorted_a || !sorted_b,
                  emit_done: emit_fire && emit_last};

  // read pointers: memory read address follows the next pointer so the
  // registered head is always current
  always_comb begin
    ia_next = ia;
    ib_next = ib;
    if (clear_now) begin
      ia_next = '0;
      ib_next = '0;
    end else if (emit_fire && (ctrl.op == stlm_pkg::OP_EMIT_MRG)) begin
      if (take_a) begin
        ia_next = ia + CW'(1);
      end else begin
        ib_next = ib + CW'(1);
      end
    end
  end

  // ---------------- list memories ----------------
  always_ff @(posedge clk) begin
    if (load_a) mem_a[count_a[AW-1:0]] <= load_val;
    rd_a <= mem_a[ia_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_b) mem_b[count_b[AW-1:0]] <= load_val;
    rd_b <= mem_b[ib_next[AW-1:0]];
  end

  // ---------------- list bookkeeping ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a  <= '0;
      count_b  <= '0;
      sorted_a <= 1'b1;
      sorted_b <= 1'b1;
      ia       <= '0;
      ib       <= '0;
    end else begin
      ia <= ia_next;
      ib <= ib_next;
      if (clear_now) begin
        count_a  <= '0;
        count_b  <= '0;
        sorted_a <= 1'b1;
        sorted_b <= 1'b1;
      end else begin
        if (load_a) begin
          count_a <= count_a + CW'(1);
          if ((count_a != '0) && (load_val < last_a)) sorted_a <= 1'b0;
        end
        if (load_b) begin
          count_b <= count_b + CW'(1);
          if ((count_b != '0) && (load_val < last_b)) sorted_b <= 1'b0;
        end
      end
    end
  end

  // tail values for the order check
  always_ff @(posedge clk) begin
    if (load_a) last_a <= load_val;
    if (load_b) last_b <= load_val;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      status <= ctrl.status;
      last   <= emit_last;
      if (ctrl.op == stlm_pkg::OP_EMIT_MRG) begin
        merged_value <= pick_wide[stlm_pkg::ITEM_W-1:0];
      end else begin
        merged_value <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/stlm_seq.sv
`default_nettype none
module stlm_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire stlm_pkg::cond_t cond,
  output stlm_pkg::ctrl_t      ctrl
);

  logic [stlm_pkg::STEP_W-1:0] step;
  logic [stlm_pkg::STEP_W-1:0] step_next;

  assign ctrl = stlm_pkg::ucode(step);

  always_comb begin
    step_next = step;
    case (ctrl.jcond)
      stlm_pkg::JC_DISPATCH: begin
        if (cond.in_fire) begin
          case (cond.action)
            stlm_pkg::ACT_LOAD_A: step_next = cond.full_a ? stlm_pkg::S_OVF : ctrl.target;
            stlm_pkg::ACT_LOAD_B: step_next = cond.full_b ? stlm_pkg::S_OVF : ctrl.target;
            stlm_pkg::ACT_MERGE:  step_next = stlm_pkg::S_CHECK;
            default:              step_next = ctrl.target;
          endcase
        end
      end
      stlm_pkg::JC_CHECK: begin
        if (cond.empty) begin
          step_next = stlm_pkg::S_EMPTY;
        end else if (cond.unsorted) begin
          step_next = stlm_pkg::S_UNSORT;
        end else begin
          step_next = ctrl.target;
        end
      end
      stlm_pkg::JC_DONE: begin
        if (cond.emit_done) step_next = ctrl.target;
      end
      default: step_next = ctrl.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= stlm_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/stlm_chk.sv
`default_nettype none
module stlm_chk (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic [1:0]                         action,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [stlm_pkg::ITEM_W-1:0] merged_value,
  input wire logic [1:0]                         status,
  input wire logic                               last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(merged_value) &&
                                $stable(status) && $stable(last))
    else $error("output changed while stalled");

  // error results are single and final
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != stlm_pkg::ST_SUCCESS) |-> last)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != stlm_pkg::ST_SUCCESS) |-> (merged_value == '0))
    else $error("error result with nonzero value");

  // a merge transfer always goes through the check step
  a_merge_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == stlm_pkg::ACT_MERGE) |=> !in_ready)
    else $error("input taken right after merge");

endmodule

bind sorted_two_list_merge_top stlm_chk u_stlm_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .action       (action),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .merged_value (merged_value),
  .status       (status),
  .last         (last)
);
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
module testbench;

  // Action code 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int DEPTH          = stlm_pkg::LIST_DEPTH_DEF;
  localparam int VAL_MIN        = 32'h8000_0000;
  localparam int VAL_MAX        = 32'h7FFF_FFFF;
  localparam int RANDOM_ITEMS   = 130;
  localparam int IDLE_PCT       = 27;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int DIRECTED_ROWS  = 25;

  // One output transfer: what the scoreboard keeps per expected result.
  typedef struct packed {
    logic signed [stlm_pkg::ITEM_W-1:0] value;
    logic [1:0]                         status;
    logic                               last;
  } merge_out_t;

  // Directed stimulus row. When typed is set, the single error result is
  // written into the row and the predictor's answer is not used.
  typedef struct packed {
    logic [1:0]                  act;
    logic [stlm_pkg::ITEM_W-1:0] val;
    logic                        typed;
    logic [1:0]                  st;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic [1:0]                         action;
  logic signed [stlm_pkg::ITEM_W-1:0] item_value;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [stlm_pkg::ITEM_W-1:0] merged_value;
  logic [1:0]                         status;
  logic                               last;

  sorted_two_list_merge_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .merged_value(merged_value),
    .status      (status),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the two lists. Index 0 is list A, index 1 is list B,
  // which matches bit 0 of the load action codes.
  int         shadow_vals [2][DEPTH];
  int         shadow_count [2];
  bit         shadow_sorted [2];
  bit         shadow_overflow;

  merge_out_t step_results [$];   // results of the action just applied
  merge_out_t results_due [$];    // oldest expected output first
  merge_out_t head;

  stim_row_t  directed_rows [DIRECTED_ROWS];
  int         load_vals [2][DEPTH + 4];

  int         error_count = 0;
  int         loads_and_merges = 0;
  int         idle_cycles = 0;
  bit         steady = 1'b0;        // both sides stop idling while set
  bit         hold_off_req = 1'b0;  // asks the receiver for one long stall

  function automatic merge_out_t error_result(input logic [1:0] st);
    merge_out_t r;
    r.value  = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic merge_out_t data_result(input int v, input bit is_last);
    merge_out_t r;
    r.value  = v;
    r.status = stlm_pkg::ST_SUCCESS;
    r.last   = is_last;
    return r;
  endfunction

  // Applies one accepted action to the shadow lists and leaves the results
  // it causes in step_results.
  task automatic apply_to_shadow_lists(input logic [1:0] act, input int val);
    int sel;
    int ia;
    int ib;
    int total;
    int k;
    bit take_a;
    step_results.delete();
    case (act)
      stlm_pkg::ACT_LOAD_A, stlm_pkg::ACT_LOAD_B: begin
        sel = int'(act[0]);
        if (shadow_count[sel] >= DEPTH) begin
          // full list: value dropped, state otherwise untouched
          shadow_overflow = 1'b1;
          step_results.push_back(error_result(stlm_pkg::ST_OVERFLOW));
        end else begin
          if (shadow_count[sel] > 0 && val < shadow_vals[sel][shadow_count[sel] - 1])
            shadow_sorted[sel] = 1'b0;
          shadow_vals[sel][shadow_count[sel]] = val;
          shadow_count[sel]++;
        end
      end
      stlm_pkg::ACT_MERGE: begin
        // empty check has priority over the sorted check
        if (shadow_count[0] == 0 || shadow_count[1] == 0) begin
          step_results.push_back(error_result(stlm_pkg::ST_EMPTY));
        end else if (!shadow_sorted[0] || !shadow_sorted[1]) begin
          step_results.push_back(error_result(stlm_pkg::ST_UNSORTED));
        end else begin
          total = shadow_count[0] + shadow_count[1];
          ia = 0;
          ib = 0;
          for (k = 0; k < total; k++) begin
            // strict less-than: on equal heads list B goes first
            take_a = ia < shadow_count[0] &&
                     (ib >= shadow_count[1] || shadow_vals[0][ia] < shadow_vals[1][ib]);
            if (take_a) begin
              step_results.push_back(data_result(shadow_vals[0][ia], k + 1 == total));
              ia++;
            end else begin
              step_results.push_back(data_result(shadow_vals[1][ib], k + 1 == total));
              ib++;
            end
          end
        end
        shadow_count[0]  = 0;
        shadow_count[1]  = 0;
        shadow_sorted[0] = 1'b1;
        shadow_sorted[1] = 1'b1;
        shadow_overflow  = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Offers one item. Entered and left at a falling edge; valid is either
  // kept high for the next item or dropped while the sender idles, never both
  // in the same step.
  task automatic send_item(input logic [1:0] act, input logic [31:0] val,
                           input bit typed, input logic [1:0] typed_status);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    item_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer happened at this edge
    apply_to_shadow_lists(act, val);
    if (typed) begin
      results_due.push_back(error_result(typed_status));
    end else begin
      foreach (step_results[i]) results_due.push_back(step_results[i]);
    end
    if (act != ACT_UNUSED) loads_and_merges++;
    @(negedge clk);
  endtask

  function automatic int pick_value(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 6) - 3;       // narrow range: many ties
      2: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return -1;
          2: return 0;
          3: return 1;
          default: return VAL_MAX;
        endcase
      end
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  task automatic fill_values(input int sel, input int n, input bit ordered);
    int mode;
    int i;
    int j;
    int key;
    mode = $urandom_range(0, 3);
    for (i = 0; i < n; i++) load_vals[sel][i] = pick_value(mode);
    if (ordered) begin
      for (i = 1; i < n; i++) begin
        key = load_vals[sel][i];
        j = i - 1;
        while (j >= 0 && load_vals[sel][j] > key) begin
          load_vals[sel][j + 1] = load_vals[sel][j];
          j--;
        end
        load_vals[sel][j + 1] = key;
      end
    end
  endtask

  // Loads two lists interleaved at random, with unused codes, then merges.
  task automatic send_list_pair(input int na, input int nb, input bit order_a,
                                input bit order_b);
    int ia;
    int ib;
    fill_values(0, na, order_a);
    fill_values(1, nb, order_b);
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 19) == 0)
        send_item(ACT_UNUSED, $urandom, 1'b0, stlm_pkg::ST_SUCCESS);
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        send_item(stlm_pkg::ACT_LOAD_A, load_vals[0][ia], 1'b0, stlm_pkg::ST_SUCCESS);
        ia++;
      end else begin
        send_item(stlm_pkg::ACT_LOAD_B, load_vals[1][ib], 1'b0, stlm_pkg::ST_SUCCESS);
        ib++;
      end
    end
    send_item(stlm_pkg::ACT_MERGE, $urandom, 1'b0, stlm_pkg::ST_SUCCESS);
  endtask

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin : receiver
    int  hold_cycles;
    bit  hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        out_ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < HOLD_OFF_CYCLES; hold_cycles++)
          @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Scoreboard: every output transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing expected", merged_value, '0);
      end else begin
        head = results_due.pop_front();
        if (merged_value !== head.value)
          report_mismatch("merged_value", merged_value, head.value);
        if (status !== head.status)
          report_mismatch("status", 32'(status), 32'(head.status));
        if (last !== head.last)
          report_mismatch("last", 32'(last), 32'(head.last));
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int seq_no;
    int kind;
    int n;
    bit pick_b;

    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = stlm_pkg::ACT_LOAD_A;
    item_value = '0;
    shadow_count[0]  = 0;
    shadow_count[1]  = 0;
    shadow_sorted[0] = 1'b1;
    shadow_sorted[1] = 1'b1;
    shadow_overflow  = 1'b0;

    directed_rows = '{
      // merge straight out of reset: both lists empty
      '{stlm_pkg::ACT_MERGE,  32'h0000_0000, 1'b1, stlm_pkg::ST_EMPTY},
      // only list A loaded, then only list B
      '{stlm_pkg::ACT_LOAD_A, 32'h7FFF_FFFF, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_MERGE,  32'h0000_0000, 1'b1, stlm_pkg::ST_EMPTY},
      '{stlm_pkg::ACT_LOAD_B, 32'h8000_0000, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_MERGE,  32'h0000_0000, 1'b1, stlm_pkg::ST_EMPTY},
      // extremes with ties at min, zero and max; unused code in between
      '{stlm_pkg::ACT_LOAD_A, 32'h8000_0000, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_A, 32'hFFFF_FFFF, 1'b0, stlm_pkg::ST_SUCCESS},
      '{ACT_UNUSED,           32'hFFFF_FFFF, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_A, 32'h0000_0000, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_A, 32'h7FFF_FFFF, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_B, 32'h8000_0000, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_B, 32'h0000_0000, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_B, 32'h7FFF_FFFF, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_MERGE,  32'hFFFF_FFFF, 1'b0, stlm_pkg::ST_SUCCESS},
      // list A out of order
      '{stlm_pkg::ACT_LOAD_A, 32'h0000_0003, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_A, 32'h0000_0002, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_B, 32'h0000_0001, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_MERGE,  32'h0000_0000, 1'b1, stlm_pkg::ST_UNSORTED},
      // list B out of order
      '{stlm_pkg::ACT_LOAD_A, 32'h0000_0001, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_B, 32'h0000_0009, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_B, 32'hFFFF_FFF7, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_MERGE,  32'h0000_0000, 1'b1, stlm_pkg::ST_UNSORTED},
      // unsorted A but B empty: the empty error wins
      '{stlm_pkg::ACT_LOAD_A, 32'h0000_0005, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_LOAD_A, 32'h0000_0004, 1'b0, stlm_pkg::ST_SUCCESS},
      '{stlm_pkg::ACT_MERGE,  32'h0000_0000, 1'b1, stlm_pkg::ST_EMPTY}
    };

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].st);

    // Random part: mostly well-formed load/merge sequences.
    loads_and_merges = 0;
    seq_no = 0;
    while (loads_and_merges < RANDOM_ITEMS) begin
      steady = (seq_no >= 5 && seq_no < 9);
      if (seq_no == 1) begin
        // both lists past capacity: overflow on each, then a 64-entry merge
        send_list_pair(DEPTH + $urandom_range(1, 2), DEPTH + $urandom_range(1, 2),
                       1'b1, 1'b1);
      end else if (seq_no == 3) begin
        // long receiver stall while loads keep coming; the merge backs up
        hold_off_req = 1'b1;
        send_list_pair($urandom_range(8, 12), $urandom_range(8, 12), 1'b1, 1'b1);
      end else begin
        kind = $urandom_range(0, 9);
        case (kind)
          6: begin
            pick_b = $urandom_range(0, 1);
            send_list_pair($urandom_range(2, 6), $urandom_range(2, 6), pick_b, !pick_b);
          end
          7: begin
            n = $urandom_range(1, 5);
            if ($urandom_range(0, 1) == 1) send_list_pair(0, n, 1'b1, 1'b1);
            else send_list_pair(n, 0, 1'b1, 1'b1);
          end
          8: begin
            repeat ($urandom_range(1, 6))
              send_item(2'($urandom_range(0, 3)), $urandom, 1'b0, stlm_pkg::ST_SUCCESS);
          end
          9: send_list_pair($urandom_range(28, 34), $urandom_range(1, 34), 1'b1, 1'b1);
          default: send_list_pair($urandom_range(1, 6), $urandom_range(1, 6), 1'b1, 1'b1);
        endcase
      end
      seq_no++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sorted_two_list_merge_top.f
hdl/stlm_pkg.sv
hdl/stlm_seq.sv
hdl/sorted_two_list_merge_top.sv
hdl/stlm_chk.sv
bench/testbench.sv
